FILE: hw/rtl/nfha_pkg.sv
// ----------------------------------------------------------------------------
// nfha_pkg: shared types and codes for the next-fit heap allocator
// Action and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package nfha_pkg;

	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_FREE   = 2'd1;
	localparam logic [1:0] ACT_RESIZE = 2'd2;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_NULL   = 3'd1;
	localparam logic [2:0] ST_OOM    = 3'd2;
	localparam logic [2:0] ST_BADFREE = 3'd3;
	localparam logic [2:0] ST_FULL   = 3'd4;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,     // wait for live mark / block size read
		S_DISPATCH,
		S_SRCH_RD,    // issue extent read for search
		S_SRCH_CHK,
		S_BUMP,
		S_DROP_RD,    // shift extents down
		S_DROP_WR,
		S_REL_RD,     // scan for insert position
		S_REL_CHK,
		S_REL_NB,     // read neighbors
		S_REL_NB2,
		S_REL_DEC,
		S_INS_RD,     // shift extents up
		S_INS_WR,
		S_FINISH,
		S_OUT
	} state_t;

endpackage

FILE: hw/rtl/next_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_heap_allocator: next-fit free-list allocator with coalescing
// Granule heap with sorted free-extent table, break pointer and live marks.
// ----------------------------------------------------------------------------
// One request at a time: ready is high only while idle with no result pending,
// and returns the cycle after the result word is taken. The time to a result
// grows with the entries in the extent table: an allocate may fall through
// to the break pointer, a next-fit hit may remove an entry so the rest of the
// table shifts down, a free scans for its sorted position and shifts on
// insert, and a moving resize allocates and then frees. Each table visit is a
// read and then a check, because the extent table is one single-port memory
// pair with a registered read. The live marks are one bit per granule in a
// memory; after reset a clearing pass over all HEAP_UNITS marks runs before
// the first word is taken. The result sits in an output register until taken.
module next_fit_heap_allocator #(
	parameter int HEAP_UNITS    = 4096,
	parameter int MAX_EXTENTS   = 64,
	parameter int GRANULE_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [15:0] request_bytes,
	input  logic [15:0] block_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] result_address,
	output logic [2:0]  status,
	output logic        moved,
	output logic [15:0] copy_bytes
);
	localparam int GW = $clog2(HEAP_UNITS);       // granule index width
	localparam int UW = GW + 1;                   // granule count width
	localparam int EW = $clog2(MAX_EXTENTS);
	localparam int CW = EW + 1;
	localparam int SH = $clog2(GRANULE_BYTES);
	localparam int WW = 17;                       // wide arithmetic width

	typedef logic [WW-1:0] w_t;

	// memories
	logic [GW-1:0] ext_start_mem [MAX_EXTENTS];
	logic [GW-1:0] ext_units_mem [MAX_EXTENTS];
	logic          live_mem      [HEAP_UNITS];
	logic [GW-1:0] bunits_mem    [HEAP_UNITS];

	nfha_pkg::state_t state_q, state_d;

	logic [12:0]   limit_q;
	logic [CW-1:0] count_q;
	logic [EW-1:0] cursor_q;
	logic [UW-1:0] brk_q;
	logic          clr_q;
	logic [GW-1:0] clr_idx_q;

	logic [1:0]  act_q;
	logic [15:0] bytes_q, addr_q;
	logic [GW-1:0] g_q;           // block being freed
	logic [UW-1:0] want_q;
	logic [GW-1:0] old_units_q;
	logic        resize_q;        // alloc step of a resize (free follows)
	logic        zfree_q;         // resize to zero
	logic        live_rd_q;
	logic [GW-1:0] bu_rd_q;
	logic [GW-1:0] es_rd_q, eu_rd_q;
	logic [CW-1:0] n_q;           // loop counter
	logic [EW-1:0] i_q;           // table index
	logic [CW-1:0] p_q;
	logic [GW-1:0] pstart_q, punits_q;
	logic          have_prev_q;
	logic [15:0]   res_q, copy_q;
	logic [2:0]    st_q;
	logic          moved_q;
	logic [2:0]    ost_q;

	// ext port
	logic          ext_we;
	logic [EW-1:0] ext_addr;
	logic [GW-1:0] ext_ws, ext_wu;
	logic          live_we, live_wd, bu_we;
	logic [GW-1:0] live_addr, bu_addr, bu_wd;

	always_ff @(posedge clk) begin
		if (ext_we) begin
			ext_start_mem[ext_addr] <= ext_ws;
			ext_units_mem[ext_addr] <= ext_wu;
		end
		es_rd_q <= ext_start_mem[ext_addr];
		eu_rd_q <= ext_units_mem[ext_addr];
	end

	always_ff @(posedge clk) begin
		if (live_we) live_mem[live_addr] <= live_wd;
		live_rd_q <= live_mem[live_addr];
	end

	always_ff @(posedge clk) begin
		if (bu_we) bunits_mem[bu_addr] <= bu_wd;
		bu_rd_q <= bunits_mem[bu_addr];
	end

	// decode of the incoming address
	logic          addr_ok;
	logic [15:0]   q_full;
	assign q_full  = (addr_q >> SH) - 16'd1;
	assign addr_ok = (addr_q >= 16'(GRANULE_BYTES)) &&
		(addr_q[SH-1:0] == '0) && (32'(q_full) < 32'(HEAP_UNITS));

	logic [UW-1:0] want_in;
	assign want_in = UW'((32'(bytes_q) + 32'(GRANULE_BYTES - 1)) >> SH);

	// shared adder / comparator
	w_t sum_a, sum_b, sum_y;
	assign sum_y = sum_a + sum_b;

	logic [UW-1:0] lim_eff;
	assign lim_eff = (32'(limit_q) < 32'(HEAP_UNITS)) ? UW'(limit_q) : UW'(HEAP_UNITS);

	logic [EW-1:0] i_next;
	logic [CW-1:0] i_inc;
	assign i_inc  = CW'(i_q) + CW'(1);
	assign i_next = (i_inc >= count_q) ? '0 : i_inc[EW-1:0];

	logic [15:0] paddr_g;     // payload address of extent read
	assign paddr_g = 16'((32'(es_rd_q) + 32'd1) << SH);

	// merge flags, computed from neighbor reads
	logic mprev, mnext;
	assign mprev = have_prev_q &&
		(w_t'(pstart_q) + w_t'(punits_q) + w_t'(1) == w_t'(g_q));
	assign mnext = (p_q < count_q) &&
		(w_t'(g_q) + w_t'(old_units_q) + w_t'(1) == w_t'(es_rd_q));

	logic          upd_count, upd_cursor, upd_brk;
	logic [CW-1:0] count_d;
	logic [EW-1:0] cursor_d;
	logic [UW-1:0] brk_d;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= nfha_pkg::S_IDLE;
			limit_q   <= 13'd4096;
			count_q   <= '0;
			cursor_q  <= '0;
			brk_q     <= '0;
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) limit_q <= cfg_wdata;
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + GW'(1);
				if (32'(clr_idx_q) == HEAP_UNITS - 1) clr_q <= 1'b0;
			end
			if (state_q == nfha_pkg::S_OUT) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (upd_count) count_q <= count_d;
			if (upd_cursor) cursor_q <= cursor_d;
			if (upd_brk) brk_q <= brk_d;
		end
	end

	// datapath register updates, driven from the sequencer
	logic ld_in, ld_p, ld_prev;
	logic [CW-1:0] n_d;
	logic [EW-1:0] i_d;
	logic [CW-1:0] p_d;
	logic ld_n, ld_i, ld_res, ld_st, ld_want, ld_old, ld_g;
	logic [15:0] res_d;
	logic [2:0]  st_d;
	logic        set_resize, clr_resize, set_moved, ld_copy;

	always_ff @(posedge clk) begin
		if (ld_in) begin
			act_q    <= action;
			bytes_q  <= request_bytes;
			addr_q   <= block_address;
			moved_q  <= 1'b0;
			copy_q   <= '0;
			res_q    <= '0;
			st_q     <= nfha_pkg::ST_OK;
			resize_q <= 1'b0;
			zfree_q  <= 1'b0;
		end
		if (ld_g) g_q <= q_full[GW-1:0];
		if (ld_want) want_q <= want_in;
		if (ld_old) old_units_q <= bu_rd_q;
		if (ld_n) n_q <= n_d;
		if (ld_i) i_q <= i_d;
		if (ld_p) p_q <= p_d;
		if (ld_prev) begin
			pstart_q    <= es_rd_q;
			punits_q    <= eu_rd_q;
		end
		if (ld_p) have_prev_q <= (p_d != '0);
		if (ld_res) res_q <= res_d;
		if (ld_st) st_q <= st_d;
		if (set_resize) resize_q <= 1'b1;
		if (clr_resize) resize_q <= 1'b0;
		if (set_moved) moved_q <= 1'b1;
		if (ld_copy) copy_q <= 16'(32'(old_units_q) << SH);
		if (state_q == nfha_pkg::S_DISPATCH && act_q == nfha_pkg::ACT_RESIZE &&
			addr_q != '0 && bytes_q == '0) zfree_q <= 1'b1;
		if (state_q == nfha_pkg::S_OUT) ost_q <= st_q;
	end

	assign result_address = res_q;
	assign status         = ost_q;
	assign moved          = moved_q;
	assign copy_bytes     = copy_q;
	assign in_ready       = (state_q == nfha_pkg::S_IDLE) && !out_valid && !clr_q;

	// drop origin, alloc or free; it picks the cursor value before finish
	logic drop_for_alloc_q;
	logic set_dfa, clr_dfa;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_for_alloc_q <= 1'b0;
		end else begin
			if (set_dfa) drop_for_alloc_q <= 1'b1;
			if (clr_dfa) drop_for_alloc_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		ext_we = 1'b0; ext_addr = i_q; ext_ws = es_rd_q; ext_wu = eu_rd_q;
		live_we = clr_q; live_wd = 1'b0; live_addr = clr_q ? clr_idx_q : q_full[GW-1:0];
		bu_we = 1'b0; bu_addr = q_full[GW-1:0]; bu_wd = '0;
		upd_count = 1'b0; count_d = count_q;
		upd_cursor = 1'b0; cursor_d = cursor_q;
		upd_brk = 1'b0; brk_d = brk_q;
		ld_in = 1'b0; ld_g = 1'b0; ld_want = 1'b0; ld_old = 1'b0;
		ld_n = 1'b0; n_d = n_q; ld_i = 1'b0; i_d = i_q;
		ld_p = 1'b0; p_d = p_q; ld_prev = 1'b0;
		ld_res = 1'b0; res_d = res_q; ld_st = 1'b0; st_d = st_q;
		set_resize = 1'b0; clr_resize = 1'b0; set_moved = 1'b0; ld_copy = 1'b0;
		set_dfa = 1'b0; clr_dfa = 1'b0;
		sum_a = '0; sum_b = '0;
		case (state_q)
			nfha_pkg::S_IDLE: begin
				if (in_valid && in_ready) begin
					ld_in = 1'b1;
					state_d = nfha_pkg::S_DECODE;
				end
			end
			nfha_pkg::S_DECODE: begin
				// address read of live mark and size issued here
				ld_g = 1'b1; ld_want = 1'b1;
				state_d = nfha_pkg::S_DISPATCH;
			end
			nfha_pkg::S_DISPATCH: begin
				live_addr = g_q; bu_addr = g_q;
				ld_old = 1'b1;
				if (act_q == nfha_pkg::ACT_ALLOC ||
					(act_q == nfha_pkg::ACT_RESIZE && addr_q == '0)) begin
					if (bytes_q == '0) begin
						ld_st = 1'b1; st_d = nfha_pkg::ST_NULL;
						state_d = nfha_pkg::S_OUT;
					end else begin
						ld_n = 1'b1; n_d = '0;
						ld_i = 1'b1; i_d = (CW'(cursor_q) < count_q) ? cursor_q : '0;
						state_d = (count_q != '0) ? nfha_pkg::S_SRCH_RD : nfha_pkg::S_BUMP;
					end
				end else if (act_q == nfha_pkg::ACT_FREE) begin
					if (addr_q == '0) state_d = nfha_pkg::S_OUT;
					else if (!addr_ok || !live_rd_q) begin
						ld_st = 1'b1; st_d = nfha_pkg::ST_BADFREE;
						state_d = nfha_pkg::S_OUT;
					end else begin
						ld_p = 1'b1; p_d = '0; ld_i = 1'b1; i_d = '0;
						state_d = nfha_pkg::S_REL_RD;
					end
				end else if (act_q == nfha_pkg::ACT_RESIZE) begin
					if (!addr_ok || !live_rd_q) begin
						ld_st = 1'b1; st_d = nfha_pkg::ST_BADFREE;
						state_d = nfha_pkg::S_OUT;
					end else if (bytes_q == '0) begin
						ld_p = 1'b1; p_d = '0; ld_i = 1'b1; i_d = '0;
						state_d = nfha_pkg::S_REL_RD;
					end else if (UW'(bu_rd_q) >= want_q) begin
						ld_res = 1'b1; res_d = addr_q;
						state_d = nfha_pkg::S_OUT;
					end else begin
						set_resize = 1'b1;
						ld_n = 1'b1; n_d = '0;
						ld_i = 1'b1; i_d = (CW'(cursor_q) < count_q) ? cursor_q : '0;
						state_d = (count_q != '0) ? nfha_pkg::S_SRCH_RD : nfha_pkg::S_BUMP;
					end
				end else begin
					state_d = nfha_pkg::S_OUT;
				end
			end
			nfha_pkg::S_SRCH_RD: begin
				state_d = nfha_pkg::S_SRCH_CHK;
			end
			nfha_pkg::S_SRCH_CHK: begin
				sum_a = w_t'(want_q); sum_b = w_t'(2);
				if (UW'(eu_rd_q) >= want_q) begin
					ld_res = 1'b1; res_d = paddr_g;
					live_addr = es_rd_q; live_we = 1'b1; live_wd = 1'b1;
					bu_addr = es_rd_q; bu_we = 1'b1;
					if (w_t'(eu_rd_q) >= sum_y) begin
						bu_wd = want_q[GW-1:0];
						ext_we = 1'b1;
						ext_ws = GW'(w_t'(es_rd_q) + w_t'(want_q) + w_t'(1));
						ext_wu = GW'(w_t'(eu_rd_q) - w_t'(want_q) - w_t'(1));
						upd_cursor = 1'b1; cursor_d = i_q;
						state_d = nfha_pkg::S_FINISH;
					end else begin
						bu_wd = eu_rd_q;
						set_dfa = 1'b1;
						ld_n = 1'b1; n_d = CW'(i_q);
						state_d = nfha_pkg::S_DROP_RD;
					end
				end else if (n_q + CW'(1) >= count_q) begin
					state_d = nfha_pkg::S_BUMP;
				end else begin
					ld_n = 1'b1; n_d = n_q + CW'(1);
					ld_i = 1'b1; i_d = i_next;
					state_d = nfha_pkg::S_SRCH_RD;
				end
			end
			nfha_pkg::S_BUMP: begin
				sum_a = w_t'(brk_q); sum_b = w_t'(want_q) + w_t'(1);
				if (sum_y > w_t'(lim_eff)) begin
					ld_st = 1'b1; st_d = nfha_pkg::ST_OOM;
					clr_resize = 1'b1;
					state_d = nfha_pkg::S_OUT;
				end else begin
					upd_brk = 1'b1; brk_d = UW'(sum_y);
					live_addr = brk_q[GW-1:0]; live_we = 1'b1; live_wd = 1'b1;
					bu_addr = brk_q[GW-1:0]; bu_we = 1'b1; bu_wd = want_q[GW-1:0];
					ld_res = 1'b1; res_d = 16'((32'(brk_q) + 32'd1) << SH);
					upd_cursor = 1'b1; cursor_d = '0;
					state_d = nfha_pkg::S_FINISH;
				end
			end
			// n_q holds the slot being filled; read n+1 then write at n
			nfha_pkg::S_DROP_RD: begin
				if (n_q + CW'(1) >= count_q) begin
					upd_count = 1'b1; count_d = count_q - CW'(1);
					if (drop_for_alloc_q) begin
						upd_cursor = 1'b1;
						cursor_d = (CW'(i_q) < count_q - CW'(1)) ? i_q : '0;
					end else begin
						upd_cursor = 1'b1; cursor_d = '0;
					end
					clr_dfa = 1'b1;
					state_d = nfha_pkg::S_FINISH;
				end else begin
					ext_addr = EW'(n_q + CW'(1));
					state_d = nfha_pkg::S_DROP_WR;
				end
			end
			nfha_pkg::S_DROP_WR: begin
				ext_we = 1'b1; ext_addr = n_q[EW-1:0];
				ld_n = 1'b1; n_d = n_q + CW'(1);
				state_d = nfha_pkg::S_DROP_RD;
			end
			// scan for first extent with start > g
			nfha_pkg::S_REL_RD: begin
				ext_addr = p_q[EW-1:0];
				state_d = nfha_pkg::S_REL_CHK;
			end
			nfha_pkg::S_REL_CHK: begin
				if (p_q < count_q && es_rd_q <= g_q) begin
					ld_p = 1'b1; p_d = p_q + CW'(1);
					state_d = nfha_pkg::S_REL_RD;
				end else begin
					ext_addr = EW'(p_q - CW'(1));
					state_d = nfha_pkg::S_REL_NB;
				end
			end
			nfha_pkg::S_REL_NB: begin
				ld_prev = 1'b1;
				ext_addr = p_q[EW-1:0];
				state_d = nfha_pkg::S_REL_NB2;
			end
			nfha_pkg::S_REL_NB2: begin
				// hold the next-neighbor read
				ext_addr = p_q[EW-1:0];
				state_d = nfha_pkg::S_REL_DEC;
			end
			nfha_pkg::S_REL_DEC: begin
				if (mprev && mnext) begin
					ext_we = 1'b1; ext_addr = EW'(p_q - CW'(1)); ext_ws = pstart_q;
					ext_wu = GW'(w_t'(punits_q) + w_t'(old_units_q) + w_t'(eu_rd_q) + w_t'(2));
					ld_n = 1'b1; n_d = p_q;
					state_d = nfha_pkg::S_DROP_RD;
				end else if (mprev) begin
					ext_we = 1'b1; ext_addr = EW'(p_q - CW'(1)); ext_ws = pstart_q;
					ext_wu = GW'(w_t'(punits_q) + w_t'(old_units_q) + w_t'(1));
					upd_cursor = 1'b1; cursor_d = '0;
					state_d = nfha_pkg::S_FINISH;
				end else if (mnext) begin
					ext_we = 1'b1; ext_addr = p_q[EW-1:0]; ext_ws = g_q;
					ext_wu = GW'(w_t'(eu_rd_q) + w_t'(old_units_q) + w_t'(1));
					upd_cursor = 1'b1; cursor_d = '0;
					state_d = nfha_pkg::S_FINISH;
				end else if (32'(count_q) >= MAX_EXTENTS) begin
					ld_st = 1'b1; st_d = nfha_pkg::ST_FULL;
					state_d = nfha_pkg::S_OUT;
				end else begin
					ld_n = 1'b1; n_d = count_q;
					state_d = nfha_pkg::S_INS_RD;
				end
			end
			// n_q is the slot being filled from n-1, down to p
			nfha_pkg::S_INS_RD: begin
				if (n_q == p_q) begin
					ext_we = 1'b1; ext_addr = p_q[EW-1:0];
					ext_ws = g_q; ext_wu = old_units_q;
					upd_count = 1'b1; count_d = count_q + CW'(1);
					upd_cursor = 1'b1; cursor_d = '0;
					state_d = nfha_pkg::S_FINISH;
				end else begin
					ext_addr = EW'(n_q - CW'(1));
					state_d = nfha_pkg::S_INS_WR;
				end
			end
			nfha_pkg::S_INS_WR: begin
				ext_we = 1'b1; ext_addr = n_q[EW-1:0];
				ld_n = 1'b1; n_d = n_q - CW'(1);
				state_d = nfha_pkg::S_INS_RD;
			end
			nfha_pkg::S_FINISH: begin
				if (resize_q) begin
					// allocation done; now free the old block
					clr_resize = 1'b1; set_moved = 1'b1; ld_copy = 1'b1;
					ld_p = 1'b1; p_d = '0;
					state_d = nfha_pkg::S_REL_RD;
				end else begin
					if (act_q == nfha_pkg::ACT_FREE || act_q == nfha_pkg::ACT_RESIZE) begin
						if (!(act_q == nfha_pkg::ACT_RESIZE && addr_q == '0) &&
							(zfree_q || moved_q)) begin
							live_addr = g_q; live_we = 1'b1; live_wd = 1'b0;
						end
						if (act_q == nfha_pkg::ACT_FREE) begin
							live_addr = g_q; live_we = 1'b1; live_wd = 1'b0;
						end
					end
					if (zfree_q) begin
						ld_st = 1'b1; st_d = nfha_pkg::ST_NULL;
					end
					state_d = nfha_pkg::S_OUT;
				end
			end
			nfha_pkg::S_OUT: begin
				state_d = nfha_pkg::S_IDLE;
			end
			default: state_d = nfha_pkg::S_IDLE;
		endcase
	end

	// a taken word is always preceded by idle with no pending result
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == nfha_pkg::S_IDLE && !out_valid))
		else $error("ready outside idle");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= MAX_EXTENTS)
		else $error("extent count overflow");
	a_brk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(brk_q) <= HEAP_UNITS)
		else $error("break beyond heap");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nfha_pkg::S_OUT) |=> out_valid)
		else $error("result not raised");
endmodule
